@@ hw/rtl/dmo_pkg.sv @@
// Shared types, sizes and constants for the dual multiwave oscillator mixer.
// Holds the quarter-wave sine table builder used by the sine ROM.
// No dependencies.
package dmo_pkg;

    // Core sizes
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS    = 16;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int INC_BITS      = 32;
    localparam int AMP_BITS      = 16;
    localparam int PW_BITS       = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_INC_A = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_INC_B = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAVEFORM_A  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAVEFORM_B  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AMP_A       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AMP_B       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_WIDTH = 3'd6;

    // Register reset values
    localparam logic [INC_BITS-1:0] RST_PHASE_INC = 32'd8947849;
    localparam logic [AMP_BITS-1:0] RST_AMP       = 16'd16384;
    localparam logic [PW_BITS-1:0]  RST_PW        = 16'd32768;

    // Waveform values are signed, -1..+1 in units of 2^-15 (+1 is 32768)
    localparam int WAVE_BITS = 17;
    localparam int ROM_BITS  = 16;

    // Quarter-wave table holds SINE_N+1 entries
    localparam int SINE_N = 1 << SINE_ADDR_BITS;
    localparam logic [SINE_ADDR_BITS:0] SINE_N_ADDR = {1'b1, {SINE_ADDR_BITS{1'b0}}};

    typedef enum logic [1:0] {
        WF_SINE     = 2'd0,
        WF_TRIANGLE = 2'd1,
        WF_RAMP     = 2'd2,
        WF_PULSE    = 2'd3
    } t_wave_sel;

    // Per-oscillator data prepared at accept time
    typedef struct packed {
        t_wave_sel                    sel;
        logic [SINE_ADDR_BITS:0]      rom_addr;
        logic                         neg;
        logic signed [WAVE_BITS-1:0]  alt;
    } t_osc_prep;

    // Per-oscillator phase events
    typedef struct packed {
        logic wrap;
        logic half;
    } t_osc_flags;

    typedef logic [ROM_BITS-1:0] t_sine_table [SINE_N+1];

    // One table entry: round(2^15 * sin(k*pi/2^(SINE_ADDR_BITS+1))) by Horner series
    function automatic logic [ROM_BITS-1:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] s;
        x  = (64'(k) * 64'd1686629713) >> SINE_ADDR_BITS;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        for (int j = 0; j < 6; j++) begin
            q = (x2 * t) >> 30;
            case (j)
                0:       q = q / 156;
                1:       q = q / 110;
                2:       q = q / 72;
                3:       q = q / 42;
                4:       q = q / 20;
                default: q = q / 6;
            endcase
            t = 64'd1073741824 - q;
        end
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32768) begin
            s = 64'd32768;
        end
        return s[ROM_BITS-1:0];
    endfunction

    function automatic t_sine_table build_sine_table();
        t_sine_table tbl;
        for (int k = 0; k <= SINE_N; k++) begin
            tbl[k] = sine_entry(k);
        end
        return tbl;
    endfunction

endpackage

@@ hw/rtl/dmo_sine_rom.sv @@
// Quarter-wave sine ROM with registered read data.
// Depends on dmo_pkg (table builder and sizes).
module dmo_sine_rom
    import dmo_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [SINE_ADDR_BITS:0]   i_addr,
    output logic [ROM_BITS-1:0]       o_data
);

    localparam t_sine_table SINE_TABLE = build_sine_table();

    logic [ROM_BITS-1:0] r_data;

    // Registered read, holds while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_TABLE[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/dmo_osc_front.sv @@
// One oscillator front end: phase advance, wrap and half-cross events,
// and waveform preparation from the current phase. Depends on dmo_pkg.
module dmo_osc_front
    import dmo_pkg::*;
(
    input  logic [PHASE_BITS-1:0] i_phase,
    input  logic [INC_BITS-1:0]   i_inc,
    input  t_wave_sel             i_sel,
    input  logic [PW_BITS-1:0]    i_pulse_width,
    output logic [PHASE_BITS-1:0] o_next_phase,
    output t_osc_flags            o_flags,
    output t_osc_prep             o_prep
);

    logic [PHASE_BITS+INC_BITS-1:0] inc_wide;
    logic [PHASE_BITS-1:0]          inc_aligned;
    logic [PHASE_BITS:0]            sum;
    logic [15:0]                    p16;
    logic [1:0]                     quad;
    logic [SINE_ADDR_BITS-1:0]      idx;
    logic signed [18:0]             tri_d;
    logic signed [18:0]             tri_v;
    logic signed [18:0]             saw_v;
    logic signed [WAVE_BITS-1:0]    alt_v;

    // Align the 32-bit increment to the accumulator width
    assign inc_wide    = {i_inc, {PHASE_BITS{1'b0}}};
    assign inc_aligned = inc_wide[PHASE_BITS+INC_BITS-1:INC_BITS];

    // Phase advance and events
    assign sum          = {1'b0, i_phase} + {1'b0, inc_aligned};
    assign o_next_phase = sum[PHASE_BITS-1:0];
    assign o_flags.wrap = sum[PHASE_BITS];
    assign o_flags.half = sum[PHASE_BITS-1] && (sum[PHASE_BITS] || !i_phase[PHASE_BITS-1]);

    // Phase fields of the current (pre-advance) phase
    assign p16  = i_phase[PHASE_BITS-1 -: 16];
    assign quad = i_phase[PHASE_BITS-1 -: 2];
    assign idx  = i_phase[PHASE_BITS-3 -: SINE_ADDR_BITS];

    // Sine: mirror the index in odd quadrants, negate in the second half of the cycle
    assign o_prep.sel      = i_sel;
    assign o_prep.rom_addr = quad[0] ? (SINE_N_ADDR - {1'b0, idx}) : {1'b0, idx};
    assign o_prep.neg      = quad[1];

    // Triangle |4p - 2| - 1, saw 1 - 2p
    assign tri_d = $signed({2'b00, p16, 1'b0}) - 19'sd65536;
    assign tri_v = (tri_d < 0 ? -tri_d : tri_d) - 19'sd32768;
    assign saw_v = 19'sd32768 - $signed({3'b000, p16});

    // Non-sine waveform value
    always_comb begin
        unique case (i_sel)
            WF_TRIANGLE: alt_v = tri_v[WAVE_BITS-1:0];
            WF_RAMP:     alt_v = saw_v[WAVE_BITS-1:0];
            WF_PULSE:    alt_v = (p16 < i_pulse_width) ? 17'sd32768 : -17'sd32768;
            default:     alt_v = '0;
        endcase
    end

    assign o_prep.alt = alt_v;

endmodule

@@ hw/rtl/dual_multiwave_oscillator_mixer_core.sv @@
// Top level of the dual multiwave oscillator mixer: config registers,
// phase accumulators, four-stage mix pipeline. Depends on dmo_pkg,
// dmo_osc_front and dmo_sine_rom.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------
//  input    | in        | i_valid / o_ready      | i_tick
//  result   | out       | o_valid / i_ready      | o_sample, o_cycle_end_a/b,
//           |           |                        | o_half_cross_a/b
//  config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One transaction is accepted per cycle while o_ready is high. Four register
// stages (front end, sine ROM read, gain multipliers, mix and saturate) lie
// between an accepted input and its result.
// Phase accumulators are loaded when a transaction with tick high is accepted.
// Each stage holds only while the stage after it is full and stalled, so
// bubbles are squeezed out and input is taken while a result waits.
// Reset clears phases and valid bits and loads config registers with their reset values; no clearing pass.
// A transaction with tick low is consumed and produces no result.
module dual_multiwave_oscillator_mixer_core
    import dmo_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_tick,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_cycle_end_a,
    output logic                          o_cycle_end_b,
    output logic                          o_half_cross_a,
    output logic                          o_half_cross_b,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int PROD_BITS = WAVE_BITS + AMP_BITS + 1;
    localparam int MIX_BITS  = PROD_BITS + 1;
    localparam int SH        = 32 - SAMPLE_BITS;
    localparam logic signed [MIX_BITS-1:0] ROUND_HALF = MIX_BITS'(1) << (SH - 1);
    localparam logic signed [MIX_BITS-1:0] SAT_MAX    =
        (MIX_BITS'(1) << (SAMPLE_BITS - 1)) - MIX_BITS'(1);
    localparam logic signed [MIX_BITS-1:0] SAT_MIN    = -(MIX_BITS'(1) << (SAMPLE_BITS - 1));

    // Configuration registers
    logic [INC_BITS-1:0]   r_inc_a, r_inc_b;
    t_wave_sel             r_wave_a, r_wave_b;
    logic [AMP_BITS-1:0]   r_amp_a, r_amp_b;
    logic [PW_BITS-1:0]    r_pw;

    // Phase accumulators
    logic [PHASE_BITS-1:0] r_phase_a, r_phase_b;
    logic [PHASE_BITS-1:0] n_phase_a, n_phase_b;

    // Pipeline
    logic                        r_v1, r_v2, r_v3, r_v4;
    logic                        en1, en2, en3, en4;
    logic                        accept;
    t_osc_prep                   n_prep_a, n_prep_b;
    t_osc_flags                  n_fl_a, n_fl_b;
    t_osc_prep                   r_prep1_a, r_prep1_b, r_prep2_a, r_prep2_b;
    t_osc_flags                  r_fl1_a, r_fl1_b, r_fl2_a, r_fl2_b;
    t_osc_flags                  r_fl3_a, r_fl3_b, r_fl4_a, r_fl4_b;
    logic [ROM_BITS-1:0]         sin_a, sin_b;
    logic signed [WAVE_BITS-1:0] wave_a, wave_b;
    logic signed [PROD_BITS-1:0] r_prod_a, r_prod_b;
    logic signed [MIX_BITS-1:0]  mix, rounded;
    logic signed [SAMPLE_BITS-1:0] n_sample, r_sample;

    // Stage enables: a stage loads when it is empty or its successor moves
    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign accept  = i_valid && en1;

    // Configuration writes, always accepted; unknown indexes are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_a  <= RST_PHASE_INC;
            r_inc_b  <= RST_PHASE_INC;
            r_wave_a <= WF_SINE;
            r_wave_b <= WF_SINE;
            r_amp_a  <= RST_AMP;
            r_amp_b  <= RST_AMP;
            r_pw     <= RST_PW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PHASE_INC_A: r_inc_a  <= i_cfg_data[INC_BITS-1:0];
                CFG_PHASE_INC_B: r_inc_b  <= i_cfg_data[INC_BITS-1:0];
                CFG_WAVEFORM_A:  r_wave_a <= t_wave_sel'(i_cfg_data[1:0]);
                CFG_WAVEFORM_B:  r_wave_b <= t_wave_sel'(i_cfg_data[1:0]);
                CFG_AMP_A:       r_amp_a  <= i_cfg_data[AMP_BITS-1:0];
                CFG_AMP_B:       r_amp_b  <= i_cfg_data[AMP_BITS-1:0];
                CFG_PULSE_WIDTH: r_pw     <= i_cfg_data[PW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Oscillator front ends
    dmo_osc_front u_front_a (
        .i_phase       (r_phase_a),
        .i_inc         (r_inc_a),
        .i_sel         (r_wave_a),
        .i_pulse_width (r_pw),
        .o_next_phase  (n_phase_a),
        .o_flags       (n_fl_a),
        .o_prep        (n_prep_a)
    );

    dmo_osc_front u_front_b (
        .i_phase       (r_phase_b),
        .i_inc         (r_inc_b),
        .i_sel         (r_wave_b),
        .i_pulse_width (r_pw),
        .o_next_phase  (n_phase_b),
        .o_flags       (n_fl_b),
        .o_prep        (n_prep_b)
    );

    // Stage 1: phase update and prepared waveform data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_a <= '0;
            r_phase_b <= '0;
            r_v1      <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept && i_tick;
            if (accept && i_tick) begin
                r_phase_a <= n_phase_a;
                r_phase_b <= n_phase_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_prep1_a <= n_prep_a;
            r_prep1_b <= n_prep_b;
            r_fl1_a   <= n_fl_a;
            r_fl1_b   <= n_fl_b;
        end
    end

    // Stage 2: sine ROM reads
    dmo_sine_rom u_rom_a (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_addr (r_prep1_a.rom_addr),
        .o_data (sin_a)
    );

    dmo_sine_rom u_rom_b (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_addr (r_prep1_b.rom_addr),
        .o_data (sin_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_prep2_a <= r_prep1_a;
            r_prep2_b <= r_prep1_b;
            r_fl2_a   <= r_fl1_a;
            r_fl2_b   <= r_fl1_b;
        end
    end

    // Stage 3: pick the waveform value and apply gain
    function automatic logic signed [WAVE_BITS-1:0] pick_wave(
        input t_osc_prep           prep,
        input logic [ROM_BITS-1:0] sine
    );
        logic signed [WAVE_BITS-1:0] s;
        s = $signed({1'b0, sine});
        if (prep.sel == WF_SINE) begin
            return prep.neg ? -s : s;
        end
        return prep.alt;
    endfunction

    assign wave_a = pick_wave(r_prep2_a, sin_a);
    assign wave_b = pick_wave(r_prep2_b, sin_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_prod_a <= PROD_BITS'(wave_a * $signed({1'b0, r_amp_a}));
            r_prod_b <= PROD_BITS'(wave_b * $signed({1'b0, r_amp_b}));
            r_fl3_a  <= r_fl2_a;
            r_fl3_b  <= r_fl2_b;
        end
    end

    // Stage 4: mix, round half up, saturate
    assign mix     = MIX_BITS'(r_prod_a) + MIX_BITS'(r_prod_b);
    assign rounded = (mix + ROUND_HALF) >>> SH;

    always_comb begin
        if (rounded > SAT_MAX) begin
            n_sample = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (rounded < SAT_MIN) begin
            n_sample = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            n_sample = rounded[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_sample <= n_sample;
            r_fl4_a  <= r_fl3_a;
            r_fl4_b  <= r_fl3_b;
        end
    end

    // Result outputs
    assign o_valid        = r_v4;
    assign o_sample       = r_sample;
    assign o_cycle_end_a  = r_fl4_a.wrap;
    assign o_cycle_end_b  = r_fl4_b.wrap;
    assign o_half_cross_a = r_fl4_a.half;
    assign o_half_cross_b = r_fl4_b.half;

endmodule
